/* hw/rtl/solss_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types of the second-order lowpass state-space core.
package solss_pkg;

    // Default sample and coefficient widths.
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int COEF_WIDTH_DEF   = 32;

    // Both filter states are signed with 16 fraction bits in this width.
    localparam int STATE_W = 48;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_A11 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_A12 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_A21 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_A22 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_B1  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_B2  = 3'd5;

    // Item modes; the fourth code does nothing.
    typedef enum logic [1:0] {
        MODE_FILTER = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_PRESET = 2'd2
    } mode_t;

endpackage

/* hw/rtl/solss_sum3.sv */
`timescale 1ns / 1ps
// One state update: two state products plus an input term, rounded and saturated.
module solss_sum3 #(
    parameter int SAMPLE_WIDTH = solss_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = solss_pkg::COEF_WIDTH_DEF
) (
    input  logic signed [COEF_WIDTH-1:0]                coef_x,
    input  logic signed [solss_pkg::STATE_W-1:0]        state_x,
    input  logic signed [COEF_WIDTH-1:0]                coef_y,
    input  logic signed [solss_pkg::STATE_W-1:0]        state_y,
    input  logic signed [SAMPLE_WIDTH+COEF_WIDTH-1:0]   drive,
    output logic signed [solss_pkg::STATE_W-1:0]        next_state
);

    localparam int STATE_W = solss_pkg::STATE_W;
    localparam int PROD_W  = STATE_W + COEF_WIDTH;
    localparam int ACC_W   = PROD_W + 2;
    localparam int SHIFT   = COEF_WIDTH - 2;
    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        {{(ACC_W-1){1'b0}}, 1'b1} << (SHIFT - 1);

    logic signed [PROD_W-1:0]       prod_x;
    logic signed [PROD_W-1:0]       prod_y;
    logic signed [ACC_W-1:0]        acc;
    logic signed [ACC_W-1:0]        scaled;
    logic [ACC_W-STATE_W:0]         top_bits;
    logic                           in_range;

    assign prod_x = PROD_W'(coef_x) * PROD_W'(state_x);
    assign prod_y = PROD_W'(coef_y) * PROD_W'(state_y);

    // Exact sum, then round half up to the state scale.
    assign acc    = ACC_W'(prod_x) + ACC_W'(prod_y) + ACC_W'(drive) + ROUND_HALF;
    assign scaled = acc >>> SHIFT;

    // The value fits when every bit above the state sign bit copies it.
    assign top_bits = scaled[ACC_W-1:STATE_W-1];
    assign in_range = (&top_bits) | ~(|top_bits);

    always_comb
    begin
        if (in_range)
        begin
            next_state = scaled[STATE_W-1:0];
        end
        else
        begin
            next_state = {scaled[ACC_W-1], {(STATE_W-1){~scaled[ACC_W-1]}}};
        end
    end

endmodule

/* hw/rtl/second_order_lowpass_state_space_core.sv */
`timescale 1ns / 1ps
// Top level of the second-order critically damped lowpass filter core.
//
// This core runs a discretized second-order critically damped lowpass filter
// in two-state form on a stream of signed Q16.16 samples. It takes one sample
// transfer in every clock cycle while sample_stall is low, and delivers the
// result of a filter-mode sample through the result register: the first stage
// forms the two input products from the sample and coefficients b1 and b2, and
// the state loop follows, where the four state products a11, a12,
// a21 and a22 against the 48-bit states are summed, rounded and saturated
// and the new output state is clipped to the sample range into the result
// register. Clear-mode and preset-mode items reset or load the states in
// order with the samples around them and give no result; the unused mode
// code does nothing. When the result register holds a stalled result, the
// first stage may still take one more sample, after which sample_stall is
// raised. Coefficients are signed Q2.30 values written over the configuration
// port, which is always ready; write them only while no item is in flight.
// After reset b1 is one and all other coefficients are zero, so the filter
// passes the samples through unchanged.
module second_order_lowpass_state_space_core #(
    parameter int SAMPLE_WIDTH = solss_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = solss_pkg::COEF_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    // Configuration write channel.
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [solss_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [COEF_WIDTH-1:0]                  cfg_data,

    // Sample channel.
    input  logic                                   sample_valid,
    output logic                                   sample_stall,
    input  logic [1:0]                             mode,
    input  logic signed [SAMPLE_WIDTH-1:0]         sample,

    // Result channel.
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic signed [SAMPLE_WIDTH-1:0]         filtered,
    output logic                                   saturated
);

    localparam int STATE_W = solss_pkg::STATE_W;
    localparam int DRIVE_W = SAMPLE_WIDTH + COEF_WIDTH;
    localparam logic signed [COEF_WIDTH-1:0] COEF_ONE =
        {2'b01, {(COEF_WIDTH-2){1'b0}}};

    // Coefficient registers.
    logic signed [COEF_WIDTH-1:0]   coef_a11_reg;
    logic signed [COEF_WIDTH-1:0]   coef_a12_reg;
    logic signed [COEF_WIDTH-1:0]   coef_a21_reg;
    logic signed [COEF_WIDTH-1:0]   coef_a22_reg;
    logic signed [COEF_WIDTH-1:0]   coef_b1_reg;
    logic signed [COEF_WIDTH-1:0]   coef_b2_reg;

    // First stage: the accepted item and its two input products.
    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    logic [1:0]                     s1_mode_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_sample_reg;
    logic signed [DRIVE_W-1:0]      s1_drive1_reg;
    logic signed [DRIVE_W-1:0]      s1_drive2_reg;
    logic signed [DRIVE_W-1:0]      s1_drive1_next;
    logic signed [DRIVE_W-1:0]      s1_drive2_next;

    // Filter states.
    logic signed [STATE_W-1:0]      output_state_reg;
    logic signed [STATE_W-1:0]      output_state_next;
    logic signed [STATE_W-1:0]      derivative_state_reg;
    logic signed [STATE_W-1:0]      derivative_state_next;
    logic signed [STATE_W-1:0]      output_update;
    logic signed [STATE_W-1:0]      derivative_update;

    // Result register.
    logic                           result_valid_reg;
    logic                           result_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] filtered_reg;
    logic signed [SAMPLE_WIDTH-1:0] filtered_next;
    logic                           saturated_reg;
    logic                           saturated_next;

    // Handshake terms.
    logic                           sample_accept;
    logic                           out_free;
    logic                           s1_take;
    logic                           s1_is_filter;

    logic [STATE_W-SAMPLE_WIDTH:0]  out_top_bits;
    logic                           out_in_range;

    // ------------------------------------------------------------------
    // Configuration. The port never pushes back.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a11_reg <= '0;
            coef_a12_reg <= '0;
            coef_a21_reg <= '0;
            coef_a22_reg <= '0;
            coef_b1_reg  <= COEF_ONE;
            coef_b2_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                solss_pkg::CFG_A11: coef_a11_reg <= cfg_data;
                solss_pkg::CFG_A12: coef_a12_reg <= cfg_data;
                solss_pkg::CFG_A21: coef_a21_reg <= cfg_data;
                solss_pkg::CFG_A22: coef_a22_reg <= cfg_data;
                solss_pkg::CFG_B1:  coef_b1_reg  <= cfg_data;
                solss_pkg::CFG_B2:  coef_b2_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. The item in the first stage moves on whenever the
    // result register is empty or its result is being transferred out.
    // ------------------------------------------------------------------
    assign out_free      = !result_valid_reg || !result_stall;
    assign s1_take       = s1_valid_reg && out_free;
    assign sample_stall  = s1_valid_reg && !out_free;
    assign sample_accept = sample_valid && !sample_stall;
    assign s1_is_filter  = (s1_mode_reg == solss_pkg::MODE_FILTER);

    always_comb
    begin
        if (sample_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_take)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // The input products do not depend on the states, so they are formed
    // ahead of the state loop.
    assign s1_drive1_next = DRIVE_W'(coef_b1_reg) * DRIVE_W'(sample);
    assign s1_drive2_next = DRIVE_W'(coef_b2_reg) * DRIVE_W'(sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            s1_mode_reg   <= mode;
            s1_sample_reg <= sample;
            s1_drive1_reg <= s1_drive1_next;
            s1_drive2_reg <= s1_drive2_next;
        end
    end

    // ------------------------------------------------------------------
    // State loop: both updates read the old states in the same cycle.
    // ------------------------------------------------------------------
    solss_sum3 #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_output_sum (
        .coef_x     (coef_a11_reg),
        .state_x    (output_state_reg),
        .coef_y     (coef_a12_reg),
        .state_y    (derivative_state_reg),
        .drive      (s1_drive1_reg),
        .next_state (output_update)
    );

    solss_sum3 #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_derivative_sum (
        .coef_x     (coef_a21_reg),
        .state_x    (output_state_reg),
        .coef_y     (coef_a22_reg),
        .state_y    (derivative_state_reg),
        .drive      (s1_drive2_reg),
        .next_state (derivative_update)
    );

    always_comb
    begin
        output_state_next     = output_state_reg;
        derivative_state_next = derivative_state_reg;
        if (s1_take)
        begin
            case (s1_mode_reg)
                solss_pkg::MODE_FILTER:
                begin
                    output_state_next     = output_update;
                    derivative_state_next = derivative_update;
                end
                solss_pkg::MODE_CLEAR:
                begin
                    output_state_next     = '0;
                    derivative_state_next = '0;
                end
                solss_pkg::MODE_PRESET:
                begin
                    output_state_next     = STATE_W'(s1_sample_reg);
                    derivative_state_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_state_reg     <= '0;
            derivative_state_reg <= '0;
        end
        else
        begin
            output_state_reg     <= output_state_next;
            derivative_state_reg <= derivative_state_next;
        end
    end

    // ------------------------------------------------------------------
    // Result: the new output state clipped to the sample range.
    // ------------------------------------------------------------------
    assign out_top_bits = output_update[STATE_W-1:SAMPLE_WIDTH-1];
    assign out_in_range = (&out_top_bits) | ~(|out_top_bits);

    always_comb
    begin
        if (out_in_range)
        begin
            filtered_next  = output_update[SAMPLE_WIDTH-1:0];
            saturated_next = 1'b0;
        end
        else
        begin
            filtered_next  = {output_update[STATE_W-1],
                              {(SAMPLE_WIDTH-1){~output_update[STATE_W-1]}}};
            saturated_next = 1'b1;
        end
    end

    always_comb
    begin
        if (s1_take && s1_is_filter)
        begin
            result_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take && s1_is_filter)
        begin
            filtered_reg  <= filtered_next;
            saturated_reg <= saturated_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign filtered     = filtered_reg;
    assign saturated    = saturated_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A clear item leaves both states at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_take && s1_mode_reg == solss_pkg::MODE_CLEAR)
        |=> (output_state_reg == '0 && derivative_state_reg == '0))
    else $error("states not cleared by a clear item");

    // A preset item loads the output state and zeroes the derivative state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_take && s1_mode_reg == solss_pkg::MODE_PRESET)
        |=> (derivative_state_reg == '0 &&
             output_state_reg == STATE_W'($past(s1_sample_reg))))
    else $error("preset item did not load the states");

    // A new result appears only after a filter item left the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(s1_take && s1_is_filter))
    else $error("result without a filter item");

    // A clipped result sits at one of the two limits of the sample range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && saturated_reg)
        |-> (filtered_reg == {1'b0, {(SAMPLE_WIDTH-1){1'b1}}} ||
             filtered_reg == {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}))
    else $error("saturated result is not at a range limit");

endmodule

/* tb/sv/solss_filter_checker.sv */
`timescale 1ns / 1ps
// Checker for the lowpass core: predicts every filter result and compares it.
module solss_filter_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [solss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                       cfg_data,
    input  logic                              sample_valid,
    input  logic                              sample_stall,
    input  logic [1:0]                        mode,
    input  logic signed [31:0]                sample,
    input  logic                              result_valid,
    input  logic                              result_stall,
    input  logic signed [31:0]                filtered,
    input  logic                              saturated,
    output int                                mismatch_count,
    output int                                outstanding,
    output int                                results_checked,
    output int                                clipped_results
);

    localparam int SW      = solss_pkg::SAMPLE_WIDTH_DEF;
    localparam int CW      = solss_pkg::COEF_WIDTH_DEF;
    localparam int STATE_W = solss_pkg::STATE_W;
    localparam int FRAC    = CW - 2;
    localparam int REPORT_LIMIT = 10;

    typedef logic signed [STATE_W-1:0] state_t;
    typedef logic signed [95:0]        acc_t;

    typedef struct packed {
        logic signed [SW-1:0] value;
        logic                 clipped;
    } filt_result_t;

    localparam acc_t ROUND_HALF = 96'sd1 <<< (FRAC - 1);
    localparam acc_t STATE_HI   = (96'sd1 <<< (STATE_W - 1)) - 96'sd1;
    localparam acc_t STATE_LO   = -(96'sd1 <<< (STATE_W - 1));
    localparam state_t OUT_HI   = (48'sd1 <<< (SW - 1)) - 48'sd1;
    localparam state_t OUT_LO   = -(48'sd1 <<< (SW - 1));

    logic signed [CW-1:0] coef [0:5];
    state_t               out_state;
    state_t               deriv_state;
    filt_result_t         expected_results [$];

    // Exact sum of three products, rounded half up to 16 fraction bits and
    // saturated to the state width.
    function automatic state_t mac3_round_sat(
        input logic signed [CW-1:0] c1, input state_t s1,
        input logic signed [CW-1:0] c2, input state_t s2,
        input logic signed [CW-1:0] c3, input state_t s3);
        acc_t acc;
        acc = c1 * s1 + c2 * s2 + c3 * s3 + ROUND_HALF;
        acc = acc >>> FRAC;
        if (acc > STATE_HI)
            return STATE_HI[STATE_W-1:0];
        if (acc < STATE_LO)
            return STATE_LO[STATE_W-1:0];
        return acc[STATE_W-1:0];
    endfunction

    // One filter step: both states move on from their old values together.
    function automatic filt_result_t advance_states(input state_t u);
        state_t       s1;
        state_t       s2;
        filt_result_t r;
        s1 = out_state;
        s2 = deriv_state;
        out_state   = mac3_round_sat(coef[solss_pkg::CFG_A11], s1,
                                     coef[solss_pkg::CFG_A12], s2,
                                     coef[solss_pkg::CFG_B1], u);
        deriv_state = mac3_round_sat(coef[solss_pkg::CFG_A21], s1,
                                     coef[solss_pkg::CFG_A22], s2,
                                     coef[solss_pkg::CFG_B2], u);
        if (out_state > OUT_HI)
        begin
            r.value   = OUT_HI[SW-1:0];
            r.clipped = 1'b1;
        end
        else if (out_state < OUT_LO)
        begin
            r.value   = OUT_LO[SW-1:0];
            r.clipped = 1'b1;
        end
        else
        begin
            r.value   = out_state[SW-1:0];
            r.clipped = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input bit have_want, input filt_result_t want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            if (have_want)
                $display("MISMATCH at %0t: expected filtered=%0d saturated=%0b",
                         $time, want.value, want.clipped,
                         ", got filtered=%0d saturated=%0b", filtered, saturated);
            else
                $display("MISMATCH at %0t: result filtered=%0d saturated=%0b",
                         $time, filtered, saturated, " with none expected");
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        filt_result_t want;
        if (!rst_n)
        begin
            coef[solss_pkg::CFG_A11] = '0;
            coef[solss_pkg::CFG_A12] = '0;
            coef[solss_pkg::CFG_A21] = '0;
            coef[solss_pkg::CFG_A22] = '0;
            coef[solss_pkg::CFG_B1]  = 32'sh4000_0000;
            coef[solss_pkg::CFG_B2]  = '0;
            out_state       = '0;
            deriv_state     = '0;
            expected_results.delete();
            mismatch_count  = 0;
            results_checked = 0;
            clipped_results = 0;
            outstanding    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready && cfg_index <= solss_pkg::CFG_B2)
                coef[cfg_index] = cfg_data;

            if (sample_valid && !sample_stall)
            begin
                case (mode)
                    solss_pkg::MODE_FILTER:
                        expected_results.push_back(advance_states(state_t'(sample)));
                    solss_pkg::MODE_CLEAR:
                    begin
                        out_state   = '0;
                        deriv_state = '0;
                    end
                    solss_pkg::MODE_PRESET:
                    begin
                        out_state   = state_t'(sample);
                        deriv_state = '0;
                    end
                    default: ;
                endcase
            end

            if (result_valid && !result_stall)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch(1'b0, '0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.clipped)
                        clipped_results++;
                    if (filtered !== want.value || saturated !== want.clipped)
                        report_mismatch(1'b1, want);
                end
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

/* tb/sv/tb_second_order_lowpass_state_space_core.sv */
`timescale 1ns / 1ps
// Testbench top for the lowpass core: stimulus, result back-pressure and verdict.
module tb_second_order_lowpass_state_space_core;

    // Timing of the run. SETTLE_CYCLES of settling cover clear and preset items
    // that are still in the pipeline when the last result has come out.
    localparam int RESET_CYCLES    = 3;
    localparam int SETTLE_CYCLES   = 6;
    localparam int MAX_WAIT        = 16;
    localparam int HOLD_CYCLES     = 300;
    localparam int PRESSURE_ITEMS  = 40;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 180;
    // No transfer on any channel for this long means the core is hung. The
    // longest legal quiet stretch is the long receiver hold plus one gap.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int IDX_W           = solss_pkg::CFG_INDEX_W;

    // The fourth mode code has no name in the package; the core ignores it.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic signed [31:0] ONE_Q30    = 32'sh4000_0000;
    localparam logic signed [31:0] COEF_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] COEF_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAMPLE_MIN = 32'sh8000_0000;

    // Coefficient settings that the random phases go through.
    typedef enum int {
        COEF_LOWPASS,
        COEF_ALL_MAX,
        COEF_ALL_MIN,
        COEF_RANDOM,
        COEF_STABLE
    } coef_kind_t;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       cfg_valid    = 1'b0;
    logic                       cfg_ready;
    logic [IDX_W-1:0]           cfg_index    = '0;
    logic [31:0]                cfg_data     = '0;
    logic                       sample_valid = 1'b0;
    logic                       sample_stall;
    logic [1:0]                 mode         = solss_pkg::MODE_FILTER;
    logic signed [31:0]         sample       = '0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    logic signed [31:0]         filtered;
    logic                       saturated;

    int mismatch_count;
    int outstanding;
    int results_checked;
    int clipped_results;

    // Stimulus bookkeeping shared by the sender, the receiver and the summary.
    bit sender_burst   = 1'b0;
    bit receiver_burst = 1'b0;
    bit hold_request   = 1'b0;
    int pressure_left  = 0;
    int holds_done     = 0;
    int idle_cycles    = 0;
    int n_filter       = 0;
    int n_clear        = 0;
    int n_preset       = 0;
    int n_unused       = 0;
    int n_settings     = 0;

    second_order_lowpass_state_space_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .mode         (mode),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .filtered     (filtered),
        .saturated    (saturated)
    );

    solss_filter_checker filter_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .mode            (mode),
        .sample          (sample),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .filtered        (filtered),
        .saturated       (saturated),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .clipped_results (clipped_results)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The watchdog restarts on every transfer of any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // One register write; the task returns at the edge where the transfer
    // happens, so the caller may drive the next write in the same step.
    task automatic write_coef(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
    endtask

    task automatic load_coefs(input logic [31:0] a11, input logic [31:0] a12,
                              input logic [31:0] a21, input logic [31:0] a22,
                              input logic [31:0] b1,  input logic [31:0] b2);
        write_coef(solss_pkg::CFG_A11, a11);
        write_coef(solss_pkg::CFG_A12, a12);
        write_coef(solss_pkg::CFG_A21, a21);
        write_coef(solss_pkg::CFG_A22, a22);
        write_coef(solss_pkg::CFG_B1, b1);
        write_coef(solss_pkg::CFG_B2, b2);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Sends one item. The gap before it is drawn here; during a burst or the
    // pressure stretch the item follows its predecessor back to back, so valid
    // stays high across the two transfers.
    task automatic send_item(input logic [1:0] m, input logic [31:0] value);
        int gap;
        if ($urandom_range(0, 39) == 0)
            sender_burst = !sender_burst;
        if (pressure_left > 0)
        begin
            gap = 0;
            pressure_left--;
        end
        else
        begin
            gap = sender_burst ? 0 : $urandom_range(0, MAX_WAIT);
        end
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        mode         <= m;
        sample       <= value;
        do @(posedge clk); while (!(sample_valid && !sample_stall));
        case (m)
            solss_pkg::MODE_FILTER: n_filter++;
            solss_pkg::MODE_CLEAR:  n_clear++;
            solss_pkg::MODE_PRESET: n_preset++;
            default:                n_unused++;
        endcase
    endtask

    // Stops offering items and waits until every predicted result has been
    // taken. The first edge lets the checker count a transfer that happened
    // in the step this task was entered.
    task automatic drain_pipeline();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sample values: four in ten span the full range, with small values near zero
    // and the two extremes mixed in so that rounding and clipping both show up.
    function automatic logic [31:0] pick_level();
        case ($urandom_range(0, 9)) inside
            [0:3]:   return $urandom;
            [4:6]:   return int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            7:       return SAMPLE_MAX;
            8:       return SAMPLE_MIN;
            default: return int'($urandom_range(0, 4)) - 2;
        endcase
    endfunction

    // Random Q2.30 value in [-1.0, 1.0).
    function automatic logic [31:0] pick_unit_coef();
        return int'($urandom_range(0, 32'h7FFF_FFFF)) - ONE_Q30;
    endfunction

    task automatic setup_coefs(input coef_kind_t kind);
        case (kind)
            // A critically damped lowpass with a corner well below the rate.
            COEF_LOWPASS: load_coefs(32'sd1068694554, 32'sd97174000, -32'sd9663676,
                                     32'sd874360000, 32'sd5046586, 32'sd9663676);
            COEF_ALL_MAX: load_coefs(COEF_MAX, COEF_MAX, COEF_MAX,
                                     COEF_MAX, COEF_MAX, COEF_MAX);
            COEF_ALL_MIN: load_coefs(COEF_MIN, COEF_MIN, COEF_MIN,
                                     COEF_MIN, COEF_MIN, COEF_MIN);
            COEF_RANDOM:  load_coefs($urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom);
            default:      load_coefs(pick_unit_coef(), pick_unit_coef(),
                                     pick_unit_coef(), pick_unit_coef(),
                                     pick_unit_coef(), pick_unit_coef());
        endcase
    endtask

    // The receiver draws a stall before each result. A pending hold request
    // turns that stall into one long stretch, during which the sender keeps
    // offering items until the core fills and stalls its input.
    initial
    begin : receiver
        int stall_cycles;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                receiver_burst = !receiver_burst;
            if (hold_request)
            begin
                stall_cycles = HOLD_CYCLES;
                hold_request = 1'b0;
                holds_done++;
            end
            else
            begin
                stall_cycles = receiver_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (stall_cycles > 0)
            begin
                result_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!(result_valid && !result_stall));
        end
    end

    initial
    begin : stimulus
        coef_kind_t  phase_kind [PHASES];
        logic [31:0] level;
        int          run_left;
        int          pick;

        phase_kind = '{COEF_LOWPASS, COEF_ALL_MAX, COEF_RANDOM, COEF_STABLE,
                       COEF_ALL_MIN, COEF_LOWPASS, COEF_RANDOM, COEF_STABLE};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first with the reset coefficients: b1 is one and the
        // rest zero, so every filter item comes back unchanged and the field
        // extremes pass straight through.
        send_item(solss_pkg::MODE_FILTER, 32'h0);
        send_item(solss_pkg::MODE_FILTER, SAMPLE_MAX);
        send_item(solss_pkg::MODE_FILTER, SAMPLE_MIN);
        send_item(solss_pkg::MODE_FILTER, 32'hFFFF_FFFF);
        send_item(solss_pkg::MODE_FILTER, 32'h0000_0001);
        send_item(MODE_UNUSED, 32'hFFFF_FFFF);
        drain_pipeline();

        // Then as an accumulator (a11 and b1 one), which makes presets and
        // clears visible and lets the output leave the sample range.
        load_coefs(ONE_Q30, '0, '0, '0, ONE_Q30, '0);
        send_item(solss_pkg::MODE_PRESET, SAMPLE_MAX);
        send_item(solss_pkg::MODE_FILTER, 32'h0000_0001);
        send_item(solss_pkg::MODE_CLEAR, 32'hFFFF_FFFF);
        send_item(solss_pkg::MODE_FILTER, 32'h0);
        send_item(solss_pkg::MODE_PRESET, SAMPLE_MIN);
        send_item(solss_pkg::MODE_FILTER, 32'hFFFF_FFFF);
        send_item(MODE_UNUSED, 32'h1234_5678);
        send_item(solss_pkg::MODE_FILTER, 32'h0);
        send_item(solss_pkg::MODE_CLEAR, 32'h0);
        send_item(solss_pkg::MODE_FILTER, 32'h5555_5555);
        send_item(solss_pkg::MODE_FILTER, 32'hAAAA_AAAA);
        send_item(solss_pkg::MODE_PRESET, 32'h0001_8000);
        send_item(solss_pkg::MODE_FILTER, 32'hFFFF_8000);

        // Random part: one coefficient setting per phase, loaded while the core
        // is idle. Samples come in steps of random length so that the filter
        // shows its settling behavior, with clears, presets and the unused
        // code sprinkled in.
        run_left = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            drain_pipeline();
            setup_coefs(phase_kind[p]);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (p == 0 && i == 20)
                begin
                    hold_request  = 1'b1;
                    pressure_left = PRESSURE_ITEMS;
                end
                if (p == 3 && i == ITEMS_PER_PHASE / 2)
                    drain_pipeline();
                if (run_left == 0)
                begin
                    level    = pick_level();
                    run_left = $urandom_range(0, 1) ? 1 : $urandom_range(4, 24);
                end
                run_left--;
                pick = $urandom_range(0, 19);
                if (pick <= 16)
                    send_item(solss_pkg::MODE_FILTER, level);
                else if (pick == 17)
                    send_item(solss_pkg::MODE_CLEAR, $urandom);
                else if (pick == 18)
                    send_item(solss_pkg::MODE_PRESET, pick_level());
                else
                    send_item(MODE_UNUSED, $urandom);
            end
        end

        drain_pipeline();

        $display("Run: %0d filter, %0d clear, %0d preset, %0d unused-code items",
                 n_filter, n_clear, n_preset, n_unused,
                 " over %0d coefficient settings", n_settings);
        $display("Run: %0d results checked, %0d clipped, %0d long receiver holds",
                 results_checked, clipped_results, holds_done,
                 ", %0d mismatches", mismatch_count);
        if (mismatch_count == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
